>>> design/tis_pkg.sv
// ----------------------------------------------------------------------------
// Triangle isoline segment package
// Shared widths, payload structs and queue entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package tis_pkg;

    localparam int INDEX_BITS = 20;
    localparam int COORD_W    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Divider pipeline: number of stages and quotient bits resolved per stage.
    localparam int DIV_STAGES    = 8;
    localparam int DIV_STEP_BITS = 32 / DIV_STAGES;

    // One triangle as it arrives on the input channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] x_first;
        logic signed [COORD_W-1:0] y_first;
        logic signed [COORD_W-1:0] value_first;
        logic [INDEX_BITS-1:0]     index_first;
        logic signed [COORD_W-1:0] x_second;
        logic signed [COORD_W-1:0] y_second;
        logic signed [COORD_W-1:0] value_second;
        logic [INDEX_BITS-1:0]     index_second;
        logic signed [COORD_W-1:0] x_third;
        logic signed [COORD_W-1:0] y_third;
        logic signed [COORD_W-1:0] value_third;
        logic [INDEX_BITS-1:0]     index_third;
    } t_tri_in;

    // One segment as it leaves on the output channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [INDEX_BITS-1:0]     start_edge_from;
        logic [INDEX_BITS-1:0]     start_edge_to;
        logic [INDEX_BITS-1:0]     end_edge_from;
        logic [INDEX_BITS-1:0]     end_edge_to;
    } t_seg_out;

    // One cut edge, prepared for the divider and the multipliers.
    typedef struct packed {
        logic signed [COORD_W-1:0] pa_x;
        logic signed [COORD_W-1:0] pa_y;
        logic                      dx_neg;
        logic [COORD_W-1:0]        dx_mag;
        logic                      dy_neg;
        logic [COORD_W-1:0]        dy_mag;
        logic [COORD_W-1:0]        num;
        logic [COORD_W-1:0]        den;
        logic [INDEX_BITS-1:0]     from_idx;
        logic [INDEX_BITS-1:0]     to_idx;
    } t_cut;

    // Queue entry: both cut edges of one triangle, first cut in slot 0.
    typedef struct packed {
        t_cut [1:0] cuts;
    } t_cut_pair;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

`default_nettype wire

>>> design/tis_fifo.sv
// ----------------------------------------------------------------------------
// Cut queue
// Small first-in first-out buffer between the classifier and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire tis_pkg::t_cut_pair     i_wdata,
    input  wire logic                   i_pop,
    output tis_pkg::t_cut_pair          o_rdata,
    output tis_pkg::t_queue_stat        o_stat
);

    tis_pkg::t_cut_pair                 r_mem [tis_pkg::QUEUE_DEPTH];
    logic [tis_pkg::QUEUE_AW-1:0]       r_wptr;
    logic [tis_pkg::QUEUE_AW-1:0]       r_rptr;
    logic [tis_pkg::QUEUE_AW:0]         r_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_stat  = '{full:  (r_count == (tis_pkg::QUEUE_AW+1)'(tis_pkg::QUEUE_DEPTH)),
                       empty: (r_count == '0)};

endmodule

`default_nettype wire

>>> design/tis_front.sv
// ----------------------------------------------------------------------------
// Triangle classifier
// Registers a triangle, marks vertices above the threshold, picks the two
// cut edges and prepares their differences for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic signed [31:0]         i_threshold,
    input  wire logic                       i_in_valid,
    output wire logic                       o_in_ready,
    input  wire tis_pkg::t_tri_in           i_tri,
    input  wire tis_pkg::t_queue_stat       i_qstat,
    output wire logic                       o_push,
    output tis_pkg::t_cut_pair              o_pair
);

    logic               r_valid;
    tis_pkg::t_tri_in   r_tri;

    logic signed [31:0] vx [3];
    logic signed [31:0] vy [3];
    logic signed [31:0] vv [3];
    logic [tis_pkg::INDEX_BITS-1:0] vi [3];
    logic [2:0] above;
    logic [2:0] cut;
    logic       emit;
    logic       drain;
    logic [1:0] sel_first;
    logic [1:0] sel_second;
    tis_pkg::t_cut edge_cut [3];

    // Input register; it frees as soon as its triangle moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_tri <= i_tri;
        end
    end

    // Vertex views.
    always_comb begin
        vx[0] = r_tri.x_first;  vy[0] = r_tri.y_first;
        vv[0] = r_tri.value_first;  vi[0] = r_tri.index_first;
        vx[1] = r_tri.x_second; vy[1] = r_tri.y_second;
        vv[1] = r_tri.value_second; vi[1] = r_tri.index_second;
        vx[2] = r_tri.x_third;  vy[2] = r_tri.y_third;
        vv[2] = r_tri.value_third;  vi[2] = r_tri.index_third;
    end

    // Above marks and the edges that change side.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            above[k] = (vv[k] > i_threshold);
        end
        cut[0] = above[0] ^ above[1];
        cut[1] = above[1] ^ above[2];
        cut[2] = above[2] ^ above[0];
        emit   = |cut;
    end

    // Per-edge differences: magnitudes of the interpolation terms.
    always_comb begin
        logic signed [32:0] n_num;
        logic signed [32:0] n_den;
        logic signed [32:0] n_dx;
        logic signed [32:0] n_dy;
        int                 b;
        for (int a = 0; a < 3; a++) begin
            b = (a == 2) ? 0 : a + 1;
            n_num = above[a] ? (33'(vv[a]) - 33'(i_threshold))
                             : (33'(i_threshold) - 33'(vv[a]));
            n_den = above[a] ? (33'(vv[a]) - 33'(vv[b]))
                             : (33'(vv[b]) - 33'(vv[a]));
            n_dx  = 33'(vx[b]) - 33'(vx[a]);
            n_dy  = 33'(vy[b]) - 33'(vy[a]);
            edge_cut[a].pa_x     = vx[a];
            edge_cut[a].pa_y     = vy[a];
            edge_cut[a].num      = n_num[31:0];
            edge_cut[a].den      = n_den[31:0];
            edge_cut[a].dx_neg   = n_dx[32];
            edge_cut[a].dx_mag   = n_dx[32] ? 32'(-n_dx) : n_dx[31:0];
            edge_cut[a].dy_neg   = n_dy[32];
            edge_cut[a].dy_mag   = n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
            edge_cut[a].from_idx = vi[a];
            edge_cut[a].to_idx   = vi[b];
        end
    end

    // First two cut edges in edge order.
    always_comb begin
        sel_first  = cut[0] ? 2'd0 : 2'd1;
        sel_second = (cut[0] && cut[1]) ? 2'd1 : 2'd2;
        o_pair.cuts[0] = edge_cut[sel_first];
        o_pair.cuts[1] = edge_cut[sel_second];
    end

    // A triangle without a cut is dropped here.
    assign drain      = r_valid && (!emit || !i_qstat.full);
    assign o_push     = r_valid && emit && !i_qstat.full;
    assign o_in_ready = !r_valid || drain;

endmodule

`default_nettype wire

>>> design/tis_back.sv
// ----------------------------------------------------------------------------
// Segment datapath
// Pipelined fraction divider, scaling multipliers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tis_pkg::t_queue_stat   i_qstat,
    input  wire tis_pkg::t_cut_pair     i_pair,
    output wire logic                   o_pop,
    output wire logic                   o_out_valid,
    input  wire logic                   i_out_ready,
    output tis_pkg::t_seg_out           o_seg
);

    typedef struct packed {
        tis_pkg::t_cut_pair cp;
        logic [1:0][32:0]   rem;
        logic [1:0][31:0]   quo;
    } t_div;

    typedef struct packed {
        tis_pkg::t_cut_pair cp;
        logic [1:0][63:0]   mx;
        logic [1:0][63:0]   my;
    } t_mul;

    t_div                         r_div   [tis_pkg::DIV_STAGES+1];
    logic [tis_pkg::DIV_STAGES:0] r_dvalid;
    t_mul                         r_mul;
    logic                         r_mvalid;
    logic                         r_ovalid;
    tis_pkg::t_seg_out            r_seg;
    logic                         adv;
    t_div                         n_div0;

    // Restoring division, a few quotient bits per stage.
    function automatic t_div div_step(input t_div d);
        t_div       res;
        logic [32:0] r;
        res = d;
        for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < tis_pkg::DIV_STEP_BITS; s++) begin
                r = {res.rem[c][31:0], 1'b0};
                if (r >= {1'b0, res.cp.cuts[c].den}) begin
                    res.rem[c] = r - {1'b0, res.cp.cuts[c].den};
                    res.quo[c] = {res.quo[c][30:0], 1'b1};
                end else begin
                    res.rem[c] = r;
                    res.quo[c] = {res.quo[c][30:0], 1'b0};
                end
            end
        end
        return res;
    endfunction

    // Start point plus the floored scaled difference.
    function automatic logic [31:0] place(input logic [31:0] pa, input logic neg,
                                          input logic [63:0] m);
        logic [64:0] up;
        logic [32:0] off;
        up  = {1'b0, m} + 65'h0_FFFF_FFFF;
        off = neg ? -up[64:32] : {1'b0, m[63:32]};
        return pa + off[31:0];
    endfunction

    // The whole pipe moves unless a result waits at the output.
    assign adv   = !r_ovalid || i_out_ready;
    assign o_pop = adv && !i_qstat.empty;

    always_comb begin
        n_div0.cp = i_pair;
        for (int c = 0; c < 2; c++) begin
            n_div0.rem[c] = {1'b0, i_pair.cuts[c].num};
            n_div0.quo[c] = '0;
        end
    end

    // Valid bits of the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_mvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_dvalid <= {r_dvalid[tis_pkg::DIV_STAGES-1:0], o_pop};
            r_mvalid <= r_dvalid[tis_pkg::DIV_STAGES];
            r_ovalid <= r_mvalid;
        end
    end

    // Divider stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_div[0] <= n_div0;
            for (int k = 0; k < tis_pkg::DIV_STAGES; k++) begin
                r_div[k+1] <= div_step(r_div[k]);
            end
        end
    end

    // Scaling products; the quotient is the fraction t.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mul.cp <= r_div[tis_pkg::DIV_STAGES].cp;
            for (int c = 0; c < 2; c++) begin
                r_mul.mx[c] <= 64'(r_div[tis_pkg::DIV_STAGES].cp.cuts[c].dx_mag)
                             * 64'(r_div[tis_pkg::DIV_STAGES].quo[c]);
                r_mul.my[c] <= 64'(r_div[tis_pkg::DIV_STAGES].cp.cuts[c].dy_mag)
                             * 64'(r_div[tis_pkg::DIV_STAGES].quo[c]);
            end
        end
    end

    // Output register with the finished segment.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_seg.start_x <= place(r_mul.cp.cuts[0].pa_x, r_mul.cp.cuts[0].dx_neg,
                                   r_mul.mx[0]);
            r_seg.start_y <= place(r_mul.cp.cuts[0].pa_y, r_mul.cp.cuts[0].dy_neg,
                                   r_mul.my[0]);
            r_seg.end_x   <= place(r_mul.cp.cuts[1].pa_x, r_mul.cp.cuts[1].dx_neg,
                                   r_mul.mx[1]);
            r_seg.end_y   <= place(r_mul.cp.cuts[1].pa_y, r_mul.cp.cuts[1].dy_neg,
                                   r_mul.my[1]);
            r_seg.start_edge_from <= r_mul.cp.cuts[0].from_idx;
            r_seg.start_edge_to   <= r_mul.cp.cuts[0].to_idx;
            r_seg.end_edge_from   <= r_mul.cp.cuts[1].from_idx;
            r_seg.end_edge_to     <= r_mul.cp.cuts[1].to_idx;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_seg       = r_seg;

endmodule

`default_nettype wire

>>> design/triangle_isoline_segment.sv
// Throughput: one triangle per cycle while the output is ready; the 8-stage divider, one 32x32 product
// stage and the output register are fully pipelined and stall together.
// Triangles without a crossing are dropped in the classifier and give no result.
// Reset: synchronous, active low; clears all valid state and sets threshold to 0.
// ----------------------------------------------------------------------------
// Triangle isoline segment
// Cuts one triangle against the isoline level and emits its segment.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_isoline_segment (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [31:0]            i_cfg_data,
    input  wire logic                   i_in_valid,
    output wire logic                   o_in_ready,
    input  wire tis_pkg::t_tri_in       i_tri,
    output wire logic                   o_out_valid,
    input  wire logic                   i_out_ready,
    output tis_pkg::t_seg_out           o_seg
);

    logic signed [31:0]     r_threshold;
    logic                   push;
    logic                   pop;
    tis_pkg::t_cut_pair     push_data;
    tis_pkg::t_cut_pair     pop_data;
    tis_pkg::t_queue_stat   qstat;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    tis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_tri       (i_tri),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_pair      (push_data)
    );

    tis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_data),
        .i_pop   (pop),
        .o_rdata (pop_data),
        .o_stat  (qstat)
    );

    tis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_pair      (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_seg       (o_seg)
    );

    // The queue is never written while full nor read while empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("cut queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("cut queue read while empty");

    // A full queue with no pop stays full in the next cycle.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qstat.full && !pop) |=> qstat.full)
        else $error("cut queue lost an entry");

endmodule

`default_nettype wire

>>> dv/triangle_isoline_segment_test.sv
// ----------------------------------------------------------------------------
// Triangle isoline segment testbench
// Drives triangles through the valid/ready input channel, predicts each
// isoline segment from the threshold and the vertex values, and compares every
// output transfer as a whole with the oldest predicted segment.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_isoline_segment_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [31:0]         i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    tis_pkg::t_tri_in    i_tri = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    tis_pkg::t_seg_out   o_seg;

    // Predictor state and bookkeeping.
    logic signed [31:0] level = '0;
    tis_pkg::t_seg_out  segments_due[$];
    int                 mismatches = 0;
    int                 triangles_sent = 0;
    int                 segments_seen = 0;
    bit                 stall_enable = 1'b1;

    triangle_isoline_segment dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_tri       (i_tri),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_seg       (o_seg)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // Gap length: mostly zero or short, occasionally long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Cut point on edge (a,b) at the isoline level, with floored scaled offsets.
    function automatic void cut_point(input logic signed [31:0] ax, ay, av,
                                      input logic signed [31:0] bx, by, bv,
                                      output logic signed [31:0] px, py);
        longint signed num, den, dx, dy;
        logic [63:0]   frac, m;
        longint signed ox, oy;
        num = longint'(level) - longint'(av);
        if (num < 0) num = -num;
        den = longint'(bv) - longint'(av);
        if (den < 0) den = -den;
        frac = (den == 0) ? 64'd0 : ((64'(num) << 32) / 64'(den));
        if (frac > 64'hFFFF_FFFF) frac = 64'hFFFF_FFFF;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        m = 64'(dx < 0 ? -dx : dx) * frac;
        ox = (dx >= 0) ? longint'(m >> 32) : -longint'((m + 64'hFFFF_FFFF) >> 32);
        m = 64'(dy < 0 ? -dy : dy) * frac;
        oy = (dy >= 0) ? longint'(m >> 32) : -longint'((m + 64'hFFFF_FFFF) >> 32);
        px = 32'(longint'(ax) + ox);
        py = 32'(longint'(ay) + oy);
    endfunction

    // Segment of one triangle at the current level, if it crosses.
    function automatic bit predict_segment(input tis_pkg::t_tri_in t,
                                           output tis_pkg::t_seg_out s);
        logic signed [31:0] vx[3], vy[3], vv[3];
        logic [tis_pkg::INDEX_BITS-1:0] vi[3];
        bit above[3];
        logic signed [31:0] cx[2], cy[2];
        logic [tis_pkg::INDEX_BITS-1:0] ef[2], et[2];
        int n, j;
        vx = '{t.x_first, t.x_second, t.x_third};
        vy = '{t.y_first, t.y_second, t.y_third};
        vv = '{t.value_first, t.value_second, t.value_third};
        vi = '{t.index_first, t.index_second, t.index_third};
        n = 0;
        s = '0;
        for (int i = 0; i < 3; i++) above[i] = vv[i] > level;
        if (above[0] == above[1] && above[1] == above[2]) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            j = (i == 2) ? 0 : i + 1;
            if (above[i] != above[j] && n < 2) begin
                cut_point(vx[i], vy[i], vv[i], vx[j], vy[j], vv[j], cx[n], cy[n]);
                ef[n] = vi[i];
                et[n] = vi[j];
                n++;
            end
        end
        s.start_x = cx[0];
        s.start_y = cy[0];
        s.end_x = cx[1];
        s.end_y = cy[1];
        s.start_edge_from = ef[0];
        s.start_edge_to = et[0];
        s.end_edge_from = ef[1];
        s.end_edge_to = et[1];
        return 1'b1;
    endfunction

    // Send one triangle and record its predicted segment on transfer.
    // Valid stays high when the next triangle follows at once; otherwise it
    // drops for the gap, and drain() drops it before any pause.
    task automatic send_triangle(input tis_pkg::t_tri_in t, input bit gaps = 1'b1);
        tis_pkg::t_seg_out s;
        int g;
        i_in_valid <= 1'b1;
        i_tri <= t;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_segment(t, s)) segments_due.insert(segments_due.size(), s);
        triangles_sent++;
        g = gaps ? gap_length() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Wait until every predicted segment has arrived, then let the pipe drain.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_level(input logic signed [31:0] th);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= th;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        level = th;
    endtask

    function automatic tis_pkg::t_tri_in make_triangle(input logic signed [31:0] v0,
                                                       v1, v2);
        tis_pkg::t_tri_in t;
        logic [351:0]     raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        t = raw[$bits(tis_pkg::t_tri_in)-1:0];
        t.value_first = v0;
        t.value_second = v1;
        t.value_third = v2;
        return t;
    endfunction

    // Random value near the level, at the level, or anywhere.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return level;
        if (r < 6) return 32'(longint'(level) + $signed($urandom_range(0, 2000)) - 1000);
        return $urandom;
    endfunction

    // Output checker: compares every transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            segments_seen++;
            if (segments_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected segment %p", o_seg);
            end else begin
                tis_pkg::t_seg_out e;
                e = segments_due.pop_front();
                if (o_seg !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Segment mismatch: expected %p, got %p", e, o_seg);
                end
            end
        end
    end

    // Output stalls: random gaps on the ready line.
    always @(posedge i_clk) begin
        if (!stall_enable) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Directed corners: extreme fields, every crossing pattern, cuts at vertices.
    task automatic test_directed();
        logic signed [31:0] mx, mn;
        tis_pkg::t_tri_in t;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_triangle(make_triangle(1, 2, 3));
        send_triangle(make_triangle(-1, 0, -5));
        send_triangle(make_triangle(1, 0, 0));
        send_triangle(make_triangle(0, 1, 0));
        send_triangle(make_triangle(0, 0, 1));
        send_triangle(make_triangle(1, 1, 0));
        send_triangle(make_triangle(0, 1, 1));
        send_triangle(make_triangle(1, 0, 1));
        send_triangle(make_triangle(mx, mn, mn));
        send_triangle(make_triangle(mn, mx, mx));
        t = make_triangle(mx, mn, 0);
        t.x_first = mx; t.y_first = mn; t.x_second = mn; t.y_second = mx;
        t.index_first = '1; t.index_second = '0; t.index_third = '1;
        send_triangle(t);
        t = make_triangle(mn, mx, 5);
        t.x_first = mn; t.y_first = mx; t.x_second = mx; t.y_second = mn;
        t.x_third = mx; t.y_third = mn;
        send_triangle(t);
        t = make_triangle(65536, 0, -65536);
        t.x_first = 0; t.y_first = 0; t.x_second = mx; t.y_second = mn;
        t.x_third = mn; t.y_third = mx;
        send_triangle(t);
        set_level(mx);
        send_triangle(make_triangle(mx, mx, mn));
        set_level(mn);
        send_triangle(make_triangle(mn, mx, mn));
        send_triangle(make_triangle(mn, mn, mn));
        set_level(32'sh0001_8000);
        send_triangle(make_triangle(32'sh0001_8000, 32'sh0002_0000, 0));
    endtask

    // Random triangles across several levels, with one full pause midway through each level.
    task automatic test_random();
        logic signed [31:0] levels[5];
        levels = '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, $urandom, -32'sh0002_4000};
        for (int p = 0; p < 5; p++) begin
            set_level(levels[p]);
            if (p == 2) stall_enable = 1'b0;
            if (p == 3) stall_enable = 1'b1;
            for (int k = 0; k < 165; k++) begin
                if (k == 80) drain();
                send_triangle(make_triangle(pick_value(), pick_value(), pick_value()),
                              (k % 60) < 45);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain();
        $display("Sent %0d triangles: directed corners plus random sweeps at several levels.",
                 triangles_sent);
        $display("Checked %0d segments under random input gaps and output stalls.",
                 segments_seen);
        if (mismatches == 0 && segments_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire
